>>> rtl/core/fcc_pkg.sv
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types, constants and letter transforms for the file name cipher.
// ----------------------------------------------------------------------------
package fcc_pkg;

  // Buffer depth in bytes and the widths that follow from it.
  localparam int MAX_NAME = 64;
  localparam int CNT_W    = $clog2(MAX_NAME + 1);
  localparam int IDX_W    = $clog2(MAX_NAME);

  localparam int KEY_LEN   = 5;
  localparam int KEY_W     = 3;
  localparam int ALPHA     = 26;
  localparam int HALF_TURN = 13;

  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [7:0] CHAR_LA  = 8'h61;
  localparam logic [7:0] CHAR_LZ  = 8'h7A;
  localparam logic [7:0] CHAR_UA  = 8'h41;
  localparam logic [7:0] CHAR_UZ  = 8'h5A;

  typedef enum logic [1:0] {
    MODE_ATBASH  = 2'd0,
    MODE_ATB_VIG = 2'd1,
    MODE_VIG_ATB = 2'd2,
    MODE_ATB_ROT = 2'd3
  } mode_e;

  typedef enum logic [0:0] {
    ST_LOAD = 1'b0,
    ST_EMIT = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] name_byte;
    logic       end_of_name;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
    logic       truncated;
  } out_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // a word is accepted this cycle
    logic emit;   // read out the buffered name
    logic clear;  // name fully delivered, reset the counters
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic done;   // every byte read out and the pipeline is empty
  } dp_status_t;

  // Letter index of the key SISOP at a key position.
  function automatic logic [4:0] key_shift(input logic [KEY_W-1:0] kidx);
    logic [4:0] k;
    case (kidx)
      3'd0:    k = 5'd18;
      3'd1:    k = 5'd8;
      3'd2:    k = 5'd18;
      3'd3:    k = 5'd14;
      3'd4:    k = 5'd15;
      default: k = 5'd0;
    endcase
    return k;
  endfunction

  // Rotate a letter offset forward by amt, both below the alphabet size.
  function automatic logic [4:0] add_mod(input logic [4:0] x, input logic [4:0] amt);
    logic [5:0] s;
    s = {1'b0, x} + {1'b0, amt};
    if (s >= 6'(ALPHA)) begin
      s = s - 6'(ALPHA);
    end
    return s[4:0];
  endfunction

  // Full transform of one byte; non-letters pass unchanged.
  function automatic logic [7:0] transform(input logic [7:0] c,
                                           input logic [KEY_W-1:0] kidx,
                                           input mode_e mode);
    logic       is_lower;
    logic       is_upper;
    logic [7:0] base;
    logic [7:0] diff;
    logic [4:0] off;
    logic [4:0] mir;
    logic [4:0] k;
    logic [4:0] inv_k;
    logic [4:0] res;
    is_lower = (c >= CHAR_LA) && (c <= CHAR_LZ);
    is_upper = (c >= CHAR_UA) && (c <= CHAR_UZ);
    base     = is_lower ? CHAR_LA : CHAR_UA;
    diff     = c - base;
    off      = diff[4:0];
    mir      = 5'd25 - off;
    k        = key_shift(kidx);
    inv_k    = (k == 5'd0) ? 5'd0 : 5'(ALPHA) - k;
    case (mode)
      MODE_ATBASH:  res = mir;
      MODE_ATB_VIG: res = add_mod(mir, k);
      MODE_VIG_ATB: res = 5'd25 - add_mod(off, inv_k);
      default:      res = add_mod(mir, 5'(HALF_TURN));
    endcase
    if (is_lower || is_upper) begin
      return base + {3'b000, res};
    end
    return c;
  endfunction

endpackage

>>> rtl/core/fcc_ctrl.sv
// ----------------------------------------------------------------------------
// fcc_ctrl
// Sequencer that alternates between loading a name and reading it out.
// ----------------------------------------------------------------------------
module fcc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                end_of_name_i,
  input  fcc_pkg::dp_status_t status_i,
  output fcc_pkg::dp_cmd_t    cmd_o,
  output logic                in_stall_o
);
  import fcc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
        if (in_valid_i && end_of_name_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (status_i.done) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

>>> rtl/core/fcc_dp.sv
// ----------------------------------------------------------------------------
// fcc_dp
// Name buffer, counters, read pipeline and output register.
// ----------------------------------------------------------------------------
module fcc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fcc_pkg::dp_cmd_t    cmd_i,
  input  fcc_pkg::in_word_t   in_word_i,
  output fcc_pkg::dp_status_t status_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fcc_pkg::out_word_t  out_word_o
);
  import fcc_pkg::*;

  logic [7:0]       name_mem [MAX_NAME];
  logic [7:0]       rdata_q;

  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] last_dot_q;
  logic             dot_seen_q;
  mode_e            mode_q;
  logic             overflow_q;

  logic [CNT_W-1:0] rd_ptr_q;
  logic [KEY_W-1:0] key_idx_q;

  logic             s1_valid_q;
  logic [CNT_W-1:0] s1_idx_q;
  logic [KEY_W-1:0] s1_key_q;

  logic             out_valid_q;
  out_word_t        out_word_q;

  logic             wr_en;
  logic             issue;
  logic             adv2;
  logic [CNT_W-1:0] limit;
  out_word_t        s1_word;

  assign wr_en = cmd_i.load && (count_q < CNT_W'(MAX_NAME));
  assign adv2  = !out_valid_q || !out_stall_i;
  assign issue = cmd_i.emit && (rd_ptr_q != count_q) && (!s1_valid_q || adv2);
  assign limit = dot_seen_q ? CNT_W'(last_dot_q) : count_q;

  // Buffer memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      name_mem[count_q[IDX_W-1:0]] <= in_word_i.name_byte;
    end
    if (issue) begin
      rdata_q <= name_mem[rd_ptr_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      last_dot_q <= '0;
      dot_seen_q <= 1'b0;
      mode_q     <= MODE_ATBASH;
      overflow_q <= 1'b0;
      rd_ptr_q   <= '0;
      key_idx_q  <= '0;
    end else if (cmd_i.clear) begin
      count_q    <= '0;
      last_dot_q <= '0;
      dot_seen_q <= 1'b0;
      overflow_q <= 1'b0;
      rd_ptr_q   <= '0;
      key_idx_q  <= '0;
    end else begin
      if (cmd_i.load && (count_q == '0)) begin
        mode_q <= mode_e'(in_word_i.func);
      end
      if (wr_en) begin
        count_q <= count_q + CNT_W'(1);
        if (in_word_i.name_byte == CHAR_DOT) begin
          last_dot_q <= count_q[IDX_W-1:0];
          dot_seen_q <= 1'b1;
        end
      end else if (cmd_i.load) begin
        overflow_q <= 1'b1;
      end
      if (issue) begin
        rd_ptr_q  <= rd_ptr_q + CNT_W'(1);
        key_idx_q <= (key_idx_q == KEY_W'(KEY_LEN - 1)) ? '0 : key_idx_q + KEY_W'(1);
      end
    end
  end

  // Stage one holds the memory read data with its position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || adv2) begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_idx_q <= rd_ptr_q;
      s1_key_q <= key_idx_q;
    end
  end

  always_comb begin
    s1_word.out_byte  = (s1_idx_q < limit) ? transform(rdata_q, s1_key_q, mode_q) : rdata_q;
    s1_word.last_out  = ((s1_idx_q + CNT_W'(1)) == count_q);
    s1_word.truncated = overflow_q;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv2) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_valid_q) begin
      out_word_q <= s1_word;
    end
  end

  assign status_o.done = (rd_ptr_q == count_q) && !s1_valid_q && !out_valid_q;
  assign out_valid_o   = out_valid_q;
  assign out_word_o    = out_word_q;

endmodule

>>> rtl/core/filename_classical_cipher.sv
// After a name's final word is taken, each stored byte passes through the registered buffer
// read (stage one) and the output register. Throughput: one name word is taken per cycle,
// then one word is emitted per cycle while the output is not stalled; the buffer's single
// read port sets the read-out pace. Input stalls after the final word until the name drains.
// Reset is asynchronous and active low; it clears counters, flags and the sequencer, while the
// name buffer is not cleared, since only bytes written for the current name are read.
// ----------------------------------------------------------------------------
// filename_classical_cipher
// Buffers a file name and emits it through Atbash, alone or with a Vigenere or ROT13 step.
// ----------------------------------------------------------------------------
module filename_classical_cipher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fcc_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fcc_pkg::out_word_t out_word_o
);
  import fcc_pkg::*;

  // Commands from the sequencer and the drain status back from the datapath.
  dp_cmd_t    cmd;
  dp_status_t status;

  // The sequencer accepts words while loading and, after the word that ends
  // the name, holds the input stalled while the datapath reads the buffer out.
  fcc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .end_of_name_i (in_word_i.end_of_name),
    .status_i      (status),
    .cmd_o         (cmd),
    .in_stall_o    (in_stall_o)
  );

  // The datapath stores the name, tracks the last dot and the overflow, and
  // pushes each stored byte through a read stage and the output register.
  // Bytes before the last dot, or all bytes if there is no dot, are transformed; the rest pass unchanged.
  fcc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_word_i   (in_word_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
